@@ sv/assert_macros.svh @@
// Assertion helpers used by the RTL (lfu_cache_table).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define LFU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LFU_ASSERT_IMP(label, cond, cons, msg) \
  `LFU_ASSERT(label, (cond) |-> (cons), msg)

`endif

@@ sv/lfu_pkg.sv @@
package lfu_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  // request command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // operations broadcast to every cell
  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_TOUCH  = 2'd1;
  localparam logic [1:0] OP_EVICT  = 2'd2;
  localparam logic [1:0] OP_INSERT = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic       put;
  } lfu_ctl_t;

endpackage

@@ sv/lfu_cache_table.sv @@
// Key-value cache with least-frequently-used replacement, oldest entry
// losing a tie on use count.
// Channels: in_* carries one request (get or put with key and value),
// out_* carries one response per request (hit flag and read value),
// cfg_* writes capacity_in_use; the user must write it only while no
// request is in flight, which the block itself does not enforce.
// A hit, a get miss or a put miss at zero capacity is answered from the
// lookup step (accept, then a parallel key compare), once the output
// register is free. A put miss then inserts after k victim scans (one
// normally, more when capacity was lowered), each walking a token down the
// row, one cell per cycle, collecting the victim and the lowest free slot.
// Throughput: one request at a time; the next is taken once the FSM is
// back in idle, even while the previous response still waits.
// Reset: all entries invalid, occupancy zero, capacity 16.
// Stall: a finished response holds in the output register; a new response
// waits until it is taken, so nothing is lost.
module lfu_cache_table
  import lfu_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // request channel
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [63:0]      in_tdata,   // lookup_key[31:0], write_value[63:32]
  input  logic             in_tuser,   // command
  // response channel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [31:0]      out_tdata,  // read_value[31:0]
  output logic             out_tuser,  // hit
  // capacity register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int OW = $clog2(CAPACITY + 1);
  localparam int EW = (OW > CFG_W) ? OW : CFG_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_INSERT = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cap_r;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [IW-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic [IW-1:0]    free_idx_r, free_idx_nxt;

  logic             req_cmd_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;

  logic             out_valid_r, out_hit_r;
  logic [VAL_W-1:0] out_value_r;
  logic             emit;
  logic             emit_hit;
  logic [VAL_W-1:0] emit_value;

  lfu_ctl_t         ctl;
  logic [IW-1:0]    tgt_idx, bc_rank;

  logic [CAPACITY-1:0] match_vec, valid_vec;
  logic [IW-1:0]       rank_arr  [CAPACITY];
  logic [VAL_W-1:0]    value_arr [CAPACITY];

  // token chain, position 0 is the empty token fed into the first cell
  logic                tk_found      [CAPACITY+1];
  logic [COUNT_WIDTH-1:0] tk_cnt     [CAPACITY+1];
  logic [IW-1:0]       tk_rank       [CAPACITY+1];
  logic [IW-1:0]       tk_idx        [CAPACITY+1];
  logic                tk_free_found [CAPACITY+1];
  logic [IW-1:0]       tk_free_idx   [CAPACITY+1];

  logic             hit;
  logic [IW-1:0]    hit_idx, hit_rank;
  logic [VAL_W-1:0] hit_value;
  logic [EW-1:0]    occx, effx;
  logic             cap_zero, out_free, accept;

  assign tk_found[0]      = 1'b0;
  assign tk_cnt[0]        = '0;
  assign tk_rank[0]       = '0;
  assign tk_idx[0]        = '0;
  assign tk_free_found[0] = 1'b0;
  assign tk_free_idx[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    lfu_cell #(
      .CW  (COUNT_WIDTH),
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctl             (ctl),
      .tgt_idx         (tgt_idx),
      .bc_rank         (bc_rank),
      .key_in          (req_key_r),
      .value_in        (req_val_r),
      .match_o         (match_vec[i]),
      .valid_o         (valid_vec[i]),
      .rank_o          (rank_arr[i]),
      .value_o         (value_arr[i]),
      .tk_found_i      (tk_found[i]),
      .tk_cnt_i        (tk_cnt[i]),
      .tk_rank_i       (tk_rank[i]),
      .tk_idx_i        (tk_idx[i]),
      .tk_free_found_i (tk_free_found[i]),
      .tk_free_idx_i   (tk_free_idx[i]),
      .tk_found_o      (tk_found[i+1]),
      .tk_cnt_o        (tk_cnt[i+1]),
      .tk_rank_o       (tk_rank[i+1]),
      .tk_idx_o        (tk_idx[i+1]),
      .tk_free_found_o (tk_free_found[i+1]),
      .tk_free_idx_o   (tk_free_idx[i+1])
    );
  end

  // Keys are unique among valid entries, so at most one cell matches.
  always_comb begin
    hit_idx   = '0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match_vec[i]) begin
        hit_idx   = hit_idx | IW'(i);
        hit_rank  = hit_rank | rank_arr[i];
        hit_value = hit_value | value_arr[i];
      end
    end
  end

  assign hit = |match_vec;

  // capacity above the table size acts as the table size
  assign occx     = EW'(occ_r);
  assign effx     = (EW'(cap_r) > EW'(CAPACITY)) ? EW'(CAPACITY) : EW'(cap_r);
  assign cap_zero = (effx == '0);

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt    = state_r;
    occ_nxt      = occ_r;
    scan_cnt_nxt = scan_cnt_r;
    free_idx_nxt = free_idx_r;
    ctl.op       = OP_NONE;
    ctl.put      = (req_cmd_r == CMD_PUT);
    tgt_idx      = hit_idx;
    bc_rank      = hit_rank;
    emit         = 1'b0;
    emit_hit     = 1'b0;
    emit_value   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (hit) begin
          // hold until the output register is free, then touch the entry
          if (out_free) begin
            ctl.op     = OP_TOUCH;
            emit       = 1'b1;
            emit_hit   = 1'b1;
            emit_value = (req_cmd_r == CMD_PUT) ? '0 : hit_value;
            state_nxt  = ST_IDLE;
          end
        end else if (req_cmd_r == CMD_PUT && !cap_zero) begin
          scan_cnt_nxt = '0;
          state_nxt    = ST_SCAN;
        end else if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // let the token reach the end of the row
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == IW'(CAPACITY - 1)) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (occx >= effx) begin
          ctl.op  = OP_EVICT;
          tgt_idx = tk_idx[CAPACITY];
          bc_rank = tk_rank[CAPACITY];
          occ_nxt = occ_r - 1'b1;
          free_idx_nxt = (tk_free_found[CAPACITY] &&
                          tk_free_idx[CAPACITY] < tk_idx[CAPACITY]) ?
                         tk_free_idx[CAPACITY] : tk_idx[CAPACITY];
          if ((occx - 1'b1) >= effx) begin
            scan_cnt_nxt = '0;
            state_nxt    = ST_SCAN;
          end else begin
            state_nxt = ST_INSERT;
          end
        end else begin
          free_idx_nxt = tk_free_idx[CAPACITY];
          state_nxt    = ST_INSERT;
        end
      end
      ST_INSERT: begin
        tgt_idx = free_idx_r;
        if (out_free) begin
          ctl.op    = OP_INSERT;
          occ_nxt   = occ_r + 1'b1;
          emit      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      occ_r      <= occ_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      if (cfg_valid && cfg_ready) cap_r <= cfg_data;
      if (emit)            out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    free_idx_r <= free_idx_nxt;
    if (accept) begin
      req_cmd_r <= in_tuser;
      req_key_r <= in_tdata[31:0];
      req_val_r <= in_tdata[63:32];
    end
    if (emit) begin
      out_hit_r   <= emit_hit;
      out_value_r <= emit_value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = out_value_r;

  // occupancy counter agrees with the valid bits of the row
  `LFU_ASSERT(a_occ_matches_valid, occ_r == OW'($countones(valid_vec)), "occupancy mismatch")
  // an eviction always finds a victim
  `LFU_ASSERT_IMP(a_victim_found, state_r == ST_DECIDE && occx >= effx, tk_found[CAPACITY], "no victim")
  // the slot chosen for a new entry is free
  `LFU_ASSERT_IMP(a_insert_free, state_r == ST_INSERT, !valid_vec[free_idx_r], "slot in use")
  // a response is only produced from the lookup or insert step
  `LFU_ASSERT_IMP(a_emit_state, emit, state_r == ST_LOOKUP || state_r == ST_INSERT, "stray response")

endmodule

@@ sv/lfu_cell.sv @@
module lfu_cell
  import lfu_pkg::*;
#(
  parameter int CW  = 16,
  parameter int IW  = 4,
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lfu_ctl_t         ctl,
  input  logic [IW-1:0]    tgt_idx,
  input  logic [IW-1:0]    bc_rank,
  input  logic [KEY_W-1:0] key_in,
  input  logic [VAL_W-1:0] value_in,
  output logic             match_o,
  output logic             valid_o,
  output logic [IW-1:0]    rank_o,
  output logic [VAL_W-1:0] value_o,
  // victim / free-slot token, one hop per cycle
  input  logic             tk_found_i,
  input  logic [CW-1:0]    tk_cnt_i,
  input  logic [IW-1:0]    tk_rank_i,
  input  logic [IW-1:0]    tk_idx_i,
  input  logic             tk_free_found_i,
  input  logic [IW-1:0]    tk_free_idx_i,
  output logic             tk_found_o,
  output logic [CW-1:0]    tk_cnt_o,
  output logic [IW-1:0]    tk_rank_o,
  output logic [IW-1:0]    tk_idx_o,
  output logic             tk_free_found_o,
  output logic [IW-1:0]    tk_free_idx_o
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] value_r, value_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    rank_r, rank_nxt;

  logic             tk_found_r, tk_free_found_r;
  logic [CW-1:0]    tk_cnt_r;
  logic [IW-1:0]    tk_rank_r, tk_idx_r, tk_free_idx_r;

  logic sel, better;

  assign sel     = (tgt_idx == IW'(IDX));
  assign match_o = valid_r && (key_r == key_in);
  assign valid_o = valid_r;
  assign rank_o  = rank_r;
  assign value_o = value_r;

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    count_nxt = count_r;
    rank_nxt  = rank_r;
    unique case (ctl.op)
      OP_TOUCH: begin
        if (sel) begin
          rank_nxt = '0;
          if (count_r != {CW{1'b1}}) count_nxt = count_r + 1'b1;
          if (ctl.put) value_nxt = value_in;
        end else if (valid_r && rank_r < bc_rank) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      OP_EVICT: begin
        if (sel) begin
          valid_nxt = 1'b0;
        end else if (valid_r && rank_r > bc_rank) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      OP_INSERT: begin
        if (sel) begin
          valid_nxt = 1'b1;
          key_nxt   = key_in;
          value_nxt = value_in;
          count_nxt = CW'(1);
          rank_nxt  = '0;
        end else if (valid_r) begin
          rank_nxt = rank_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // lower count wins, older entry wins a tie
  assign better = valid_r && (!tk_found_i || count_r < tk_cnt_i ||
                  (count_r == tk_cnt_i && rank_r > tk_rank_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r         <= 1'b0;
      tk_found_r      <= 1'b0;
      tk_free_found_r <= 1'b0;
    end else begin
      valid_r         <= valid_nxt;
      tk_found_r      <= tk_found_i || better;
      tk_free_found_r <= tk_free_found_i || !valid_r;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    count_r <= count_nxt;
    rank_r  <= rank_nxt;
    if (better) begin
      tk_cnt_r  <= count_r;
      tk_rank_r <= rank_r;
      tk_idx_r  <= IW'(IDX);
    end else begin
      tk_cnt_r  <= tk_cnt_i;
      tk_rank_r <= tk_rank_i;
      tk_idx_r  <= tk_idx_i;
    end
    tk_free_idx_r <= (!tk_free_found_i && !valid_r) ? IW'(IDX) : tk_free_idx_i;
  end

  assign tk_found_o      = tk_found_r;
  assign tk_cnt_o        = tk_cnt_r;
  assign tk_rank_o       = tk_rank_r;
  assign tk_idx_o        = tk_idx_r;
  assign tk_free_found_o = tk_free_found_r;
  assign tk_free_idx_o   = tk_free_idx_r;

endmodule
